### hdl/bct7_pkg.sv
// shared types and constants for the two-digit countdown timer
// no dependencies

package bct7_pkg;

    localparam int StartW  = 7;
    localparam int TpsW    = 10;
    localparam int DigitW  = 4;
    localparam int SegW    = 8;
    localparam int CfgIdxW = 1;
    localparam int CfgW    = 10;

    localparam logic [StartW-1:0] StartMax   = 7'd99;
    localparam logic [StartW-1:0] StartReset = 7'd60;
    localparam logic [TpsW-1:0]   TpsReset   = 10'd100;

    localparam logic [SegW-1:0] SegDash = 8'h40;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgStartSeconds  = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 1'd1;

    // item kinds
    localparam logic ActTick   = 1'b0;
    localparam logic ActButton = 1'b1;

    typedef struct packed {
        logic              active;
        logic [DigitW-1:0] tens;
        logic [DigitW-1:0] ones;
    } timer_state_t;

    function automatic logic [SegW-1:0] digit_seg(input logic [DigitW-1:0] d);
        logic [SegW-1:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SegDash;
        endcase
        return s;
    endfunction

endpackage

### hdl/bct7_timer.sv
// countdown state: button edge detect, tick counter and digit registers
// depends on bct7_pkg

module bct7_timer import bct7_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_en,
    input  logic              action,
    input  logic              button_level,
    input  logic [StartW-1:0] start_seconds,
    input  logic [TpsW-1:0]   ticks_per_second,
    output timer_state_t      state_next
);

    logic              active_reg, active_next;
    logic              last_button_reg, last_button_next;
    logic [TpsW-1:0]   tick_count_reg, tick_count_next;
    logic [DigitW-1:0] tens_reg, tens_next;
    logic [DigitW-1:0] ones_reg, ones_next;

    logic [StartW-1:0] start_clamped;
    logic [14:0]       tens_prod;
    logic [DigitW-1:0] start_tens;
    logic [StartW-1:0] start_ones_full;
    logic [TpsW-1:0]   tps;
    logic [TpsW-1:0]   tick_inc;

    always_comb begin
        start_clamped = (start_seconds > StartMax) ? StartMax : start_seconds;
        // divide by ten via reciprocal, exact for values up to 99
        tens_prod       = 15'({8'd0, start_clamped} * 15'd205);
        start_tens      = DigitW'(tens_prod[14:11]);
        start_ones_full = start_clamped - StartW'({3'd0, start_tens} * 7'd10);
        tps             = (ticks_per_second == '0) ? TpsW'(1) : ticks_per_second;
        tick_inc        = tick_count_reg + TpsW'(1);

        active_next      = active_reg;
        last_button_next = last_button_reg;
        tick_count_next  = tick_count_reg;
        tens_next        = tens_reg;
        ones_next        = ones_reg;

        if (item_en) begin
            if (action == ActTick) begin
                if (active_reg) begin
                    if (tick_inc < tps) begin
                        tick_count_next = tick_inc;
                    end else begin
                        tick_count_next = '0;
                        if (tens_reg == '0 && ones_reg == '0) begin
                            active_next = 1'b0;
                        end else if (ones_reg == '0) begin
                            ones_next = DigitW'(9);
                            tens_next = tens_reg - DigitW'(1);
                        end else begin
                            ones_next = ones_reg - DigitW'(1);
                        end
                    end
                end
            end else begin
                if (button_level && !last_button_reg) begin
                    if (active_reg) begin
                        active_next = 1'b0;
                    end else begin
                        active_next     = 1'b1;
                        tens_next       = start_tens;
                        ones_next       = start_ones_full[DigitW-1:0];
                        tick_count_next = '0;
                    end
                end
                last_button_next = button_level;
            end
        end

        state_next.active = active_next;
        state_next.tens   = tens_next;
        state_next.ones   = ones_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            last_button_reg <= 1'b0;
            tick_count_reg  <= '0;
            tens_reg        <= '0;
            ones_reg        <= '0;
        end else begin
            active_reg      <= active_next;
            last_button_reg <= last_button_next;
            tick_count_reg  <= tick_count_next;
            tens_reg        <= tens_next;
            ones_reg        <= ones_next;
        end
    end

endmodule

### hdl/bct7_display.sv
// result register: seven-segment encoding of the timer state
// depends on bct7_pkg

module bct7_display import bct7_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  logic            unload,
    input  timer_state_t    state_next,
    output logic            out_valid,
    output logic [SegW-1:0] tens_segments,
    output logic [SegW-1:0] ones_segments,
    output logic            running
);

    logic            valid_reg, valid_next;
    logic [SegW-1:0] tens_reg, ones_reg;
    logic            running_reg;

    always_comb begin
        valid_next = valid_reg;
        if (unload) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            running_reg <= state_next.active;
            tens_reg    <= state_next.active ? digit_seg(state_next.tens) : SegDash;
            ones_reg    <= state_next.active ? digit_seg(state_next.ones) : SegDash;
        end
    end

    assign out_valid     = valid_reg;
    assign tens_segments = tens_reg;
    assign ones_segments = ones_reg;
    assign running       = running_reg;

endmodule

### hdl/button_countdown_timer_7seg.sv
// Two-digit start/stop countdown timer with seven-segment result per request.
// Each request is a timebase tick or a button sample; a rising button edge
// starts an idle timer (showing start_seconds) or stops a running one. After
// ticks_per_second ticks the display steps down by one; after 00 it shows
// dashes and goes idle. Every request gives exactly one result. A request is
// taken every clock as long as the result register is empty or being drained,
// so throughput is one request per cycle; the single result register behind
// the state update logic shows each result in the next cycle. Configuration
// writes are always accepted and must happen while the timer is quiet.
// depends on bct7_pkg, bct7_timer, bct7_display

module button_countdown_timer_7seg import bct7_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic               s_button_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SegW-1:0]    m_tens_segments,
    output logic [SegW-1:0]    m_ones_segments,
    output logic               m_running,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    logic [StartW-1:0] start_seconds_reg;
    logic [TpsW-1:0]   ticks_per_second_reg;
    logic              accept;
    timer_state_t      state_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seconds_reg    <= StartReset;
            ticks_per_second_reg <= TpsReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CfgStartSeconds:   start_seconds_reg    <= cfg_data[StartW-1:0];
                CfgTicksPerSecond: ticks_per_second_reg <= cfg_data[TpsW-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    bct7_timer u_timer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_en          (accept),
        .action           (s_action),
        .button_level     (s_button_level),
        .start_seconds    (start_seconds_reg),
        .ticks_per_second (ticks_per_second_reg),
        .state_next       (state_next)
    );

    bct7_display u_display (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .unload        (m_ready),
        .state_next    (state_next),
        .out_valid     (m_valid),
        .tens_segments (m_tens_segments),
        .ones_segments (m_ones_segments),
        .running       (m_running)
    );

endmodule

### dv/tb_button_countdown_timer_7seg.sv
`timescale 1ns / 100ps
// self-checking bench for the two-digit countdown timer: random ticks and button presses
// go in, every display result is checked against a local behavioral timer model
// depends on bct7_pkg and button_countdown_timer_7seg

module tb_button_countdown_timer_7seg;
    import bct7_pkg::*;

    localparam int WatchdogLimit = 3000;
    localparam int RandomPhases  = 12;
    localparam int PhaseRequests = 105;

    localparam logic [SegW-1:0] DigitGlyph [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct packed {
        logic action;
        logic level;
    } timer_req_t;

    typedef struct packed {
        logic [SegW-1:0] tens;
        logic [SegW-1:0] ones;
        logic            running;
    } display_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_action       = 1'b0;
    logic               s_button_level = 1'b0;
    logic               m_ready        = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic [CfgIdxW-1:0] cfg_index      = '0;
    logic [CfgW-1:0]    cfg_data       = '0;
    logic               s_ready;
    logic               m_valid;
    logic [SegW-1:0]    m_tens_segments;
    logic [SegW-1:0]    m_ones_segments;
    logic               m_running;
    logic               cfg_ready;

    // timer model state and its copy of the registers
    logic [StartW-1:0] cfg_start  = StartReset;
    logic [TpsW-1:0]   cfg_tps    = TpsReset;
    logic              tmr_active = 1'b0;
    logic              prev_level = 1'b0;
    logic [TpsW-1:0]   tick_cnt   = '0;
    logic [DigitW-1:0] tens_d     = '0;
    logic [DigitW-1:0] ones_d     = '0;

    timer_req_t pending_reqs [$];
    display_t   shown_q [$];
    timer_req_t next_req;
    display_t   want_disp;

    int  send_gap     = 0;
    int  recv_stall   = 0;
    bit  send_calm    = 1'b0;
    bit  recv_calm    = 1'b0;
    int  err_count    = 0;
    int  n_requests   = 0;
    int  n_ticks      = 0;
    int  n_results    = 0;
    int  n_starts     = 0;
    int  n_expired    = 0;
    int  n_stops      = 0;
    int  idle_cycles  = 0;

    button_countdown_timer_7seg i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_button_level  (s_button_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tens_segments (m_tens_segments),
        .m_ones_segments (m_ones_segments),
        .m_running       (m_running),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [SegW-1:0] digit_glyph(input logic [DigitW-1:0] d);
        return (d < 10) ? DigitGlyph[d] : SegDash;
    endfunction

    // mostly short gaps, now and then a long one; none at all in calm stretches
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // steps the timer model by one request and queues the display it should produce
    task automatic advance_timer(input logic act, input logic lvl);
        logic [TpsW-1:0]   tps_eff;
        logic [StartW-1:0] start_eff;
        display_t          shown;
        tps_eff   = (cfg_tps == '0) ? TpsW'(1) : cfg_tps;
        start_eff = (cfg_start > StartMax) ? StartMax : cfg_start;
        if (act == ActTick) begin
            n_ticks++;
            if (tmr_active) begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= tps_eff) begin
                    tick_cnt = '0;
                    if (tens_d == 0 && ones_d == 0) begin
                        tmr_active = 1'b0;
                        n_expired++;
                    end else if (ones_d == 0) begin
                        ones_d = 4'd9;
                        tens_d = tens_d - 1'b1;
                    end else begin
                        ones_d = ones_d - 1'b1;
                    end
                end
            end
        end else begin
            if (lvl && !prev_level) begin
                if (tmr_active) begin
                    tmr_active = 1'b0;
                    n_stops++;
                end else begin
                    tens_d     = DigitW'(start_eff / 10);
                    ones_d     = DigitW'(start_eff % 10);
                    tick_cnt   = '0;
                    tmr_active = 1'b1;
                    n_starts++;
                end
            end
            prev_level = lvl;
        end
        if (tmr_active) begin
            shown.tens    = digit_glyph(tens_d);
            shown.ones    = digit_glyph(ones_d);
            shown.running = 1'b1;
        end else begin
            shown.tens    = SegDash;
            shown.ones    = SegDash;
            shown.running = 1'b0;
        end
        shown_q.push_back(shown);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_timer(s_action, s_button_level);
                n_requests++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_action       <= next_req.action;
                    s_button_level <= next_req.level;
                    send_gap = pick_gap(send_calm);
                    if ($urandom_range(0, 79) == 0) send_calm = !send_calm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (shown_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("tb: result %0d arrived with nothing expected", n_results);
                end else begin
                    want_disp = shown_q.pop_front();
                    if (m_tens_segments !== want_disp.tens ||
                        m_ones_segments !== want_disp.ones ||
                        m_running !== want_disp.running) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("tb: result %0d exp/act tens %h/%h ones %h/%h run %b/%b",
                                     n_results, want_disp.tens, m_tens_segments,
                                     want_disp.ones, m_ones_segments,
                                     want_disp.running, m_running);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_stall = pick_gap(recv_calm);
            end
            if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
        end
    end

    // watchdog on lack of progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("tb: no progress for %0d cycles", WatchdogLimit);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_req(input logic act, input logic lvl);
        timer_req_t r;
        r.action = act;
        r.level  = lvl;
        pending_reqs.push_back(r);
    endtask

    // sender holds off until every queued request has been answered
    task automatic wait_quiet;
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || shown_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CfgStartSeconds) cfg_start = val[StartW-1:0];
        else cfg_tps = val[TpsW-1:0];
    endtask

    // press sequences with a run of ticks behind each, mixed with random noise
    task automatic fill_phase(input int n_items);
        int start_eff;
        int tps_eff;
        int full_run;
        int ticks;
        start_eff = (cfg_start > StartMax) ? StartMax : cfg_start;
        tps_eff   = (cfg_tps == '0) ? 1 : cfg_tps;
        full_run  = (start_eff + 1) * tps_eff + 1;
        while (pending_reqs.size() < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                push_req(ActButton, 1'b0);
                push_req(ActButton, 1'b1);
                repeat ($urandom_range(0, 2)) push_req(ActButton, 1'b1);
                push_req(ActButton, 1'b0);
                if (full_run <= 200 && $urandom_range(0, 1) == 0)
                    ticks = full_run + $urandom_range(0, 2);
                else
                    ticks = $urandom_range(0, 40);
                repeat (ticks) push_req(ActTick, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0) begin
                    push_req(ActButton, 1'b1);
                    push_req(ActButton, 1'b0);
                end
            end
        end
    endtask

    initial begin
        int r;
        logic [StartW-1:0] start_val;
        logic [TpsW-1:0]   tps_val;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: idle tick with button high, start, hold, release, stop
        push_req(ActTick, 1'b1);
        push_req(ActButton, 1'b1);
        push_req(ActButton, 1'b1);
        push_req(ActButton, 1'b0);
        push_req(ActTick, 1'b0);
        push_req(ActTick, 1'b1);
        push_req(ActButton, 1'b1);
        push_req(ActButton, 1'b0);
        wait_quiet;

        // start value above 99 clamps, zero ticks per second acts as one
        write_reg(CfgStartSeconds, 10'h3ff);
        write_reg(CfgTicksPerSecond, 10'd0);
        push_req(ActButton, 1'b1);
        push_req(ActTick, 1'b0);
        push_req(ActTick, 1'b1);
        push_req(ActButton, 1'b0);
        push_req(ActButton, 1'b1);
        wait_quiet;

        // start at zero: 00 for one second, then dashes; later ticks ignored
        write_reg(CfgStartSeconds, 10'd0);
        write_reg(CfgTicksPerSecond, 10'd1);
        push_req(ActButton, 1'b0);
        push_req(ActButton, 1'b1);
        push_req(ActTick, 1'b0);
        push_req(ActTick, 1'b0);
        push_req(ActButton, 1'b0);
        wait_quiet;

        // borrow from tens into ones
        write_reg(CfgStartSeconds, 10'd10);
        write_reg(CfgTicksPerSecond, 10'd2);
        push_req(ActButton, 1'b1);
        push_req(ActTick, 1'b0);
        push_req(ActTick, 1'b0);
        push_req(ActButton, 1'b0);

        for (int ph = 0; ph < RandomPhases; ph++) begin
            wait_quiet;
            case (ph)
                0: begin
                    start_val = 7'd99;
                    tps_val   = 10'd1;
                end
                1: begin
                    start_val = 7'd0;
                    tps_val   = 10'd0;
                end
                2: begin
                    start_val = 7'd127;
                    tps_val   = 10'd1023;
                end
                default: begin
                    start_val = ($urandom_range(0, 3) == 0) ? StartW'($urandom_range(0, 127))
                                                            : StartW'($urandom_range(0, 12));
                    r = $urandom_range(0, 9);
                    if (r < 8) tps_val = TpsW'($urandom_range(0, 4));
                    else if (r == 8) tps_val = 10'd1023;
                    else tps_val = TpsW'($urandom_range(5, 1023));
                end
            endcase
            write_reg(CfgStartSeconds, {3'($urandom_range(0, 7)), start_val});
            write_reg(CfgTicksPerSecond, tps_val);
            fill_phase(PhaseRequests);
        end

        wait_quiet;
        repeat (4) @(posedge aclk);
        $display("tb: %0d requests (%0d ticks), %0d results checked, %0d mismatches",
                 n_requests, n_ticks, n_results, err_count);
        $display("tb: %0d countdowns started, %0d ran out, %0d stopped by button",
                 n_starts, n_expired, n_stops);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
